[rtl/core/qas_pkg.sv]
// ----------------------------------------------------------------------------
// qas_pkg
// Shared types, constants and tables for the quadrant autotile selector.
// ----------------------------------------------------------------------------
package qas_pkg;

    // Map geometry
    localparam int MAP_W   = 32;
    localparam int MAP_H   = 32;
    localparam int COORD_W = 5;
    localparam int ADDR_W  = $clog2(MAP_W * MAP_H);
    localparam int DEPTH   = MAP_W * MAP_H;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Tile codes
    localparam logic [7:0] TILE_VACANT = 8'h00;
    localparam logic [7:0] TILE_SOLID  = 8'h01;
    localparam logic [7:0] TILE_GOAL   = 8'h02;
    localparam logic [7:0] TILE_RAW    = 8'h03;
    localparam logic [7:0] BASE_VACANT = 8'h30;
    localparam logic [7:0] BASE_SOLID  = 8'h40;

    // Quadrant codes
    localparam logic [2:0] QUAD_WHOLE = 3'd0;

    // Neighbor fetch: slot 0 is the cell itself, slots 1..8 are NW..SE
    localparam logic [3:0] SLOT_LAST = 4'd8;

    // Flag bits
    localparam logic [2:0] FL_NONE = 3'b000;
    localparam logic [2:0] FL_X    = 3'b001;
    localparam logic [2:0] FL_Y    = 3'b010;
    localparam logic [2:0] FL_S    = 3'b100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DRAIN,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic [7:0] tile_id;
        logic       flip_x;
        logic       flip_y;
        logic       swap_xy;
        logic [2:0] quadrant;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0] full;
        logic [7:0] cc1;
        logic [7:0] cc2;
        logic [7:0] hbit;
        logic [7:0] vbit;
        logic [2:0] bflags;
        logic [2:0] sflags;
    } quad_rule_t;

    localparam quad_rule_t QUAD_RULES [4] = '{
        '{8'h50, 8'h90, 8'hc0, 8'h10, 8'h40, FL_NONE,     FL_S},
        '{8'h48, 8'h28, 8'h60, 8'h08, 8'h40, FL_X,        FL_Y | FL_S},
        '{8'h12, 8'h14, 8'h06, 8'h10, 8'h02, FL_Y,        FL_S | FL_X},
        '{8'h0a, 8'h09, 8'h03, 8'h08, 8'h02, FL_X | FL_Y, FL_X | FL_Y | FL_S}
    };

    // index = N<<3 | W<<2 | E<<1 | S
    localparam logic [7:0] GOAL_TILES [16] = '{
        8'h50, 8'h60, 8'h51, 8'h61, 8'h53, 8'h63, 8'h52, 8'h62,
        8'h80, 8'h70, 8'h81, 8'h71, 8'h83, 8'h73, 8'h82, 8'h72
    };

    function automatic logic tile_match(logic [7:0] self_t, logic [7:0] other_t);
        return (self_t == other_t) || (self_t == TILE_VACANT && other_t == TILE_GOAL);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] c,
                                                   logic [COORD_W-1:0] r);
        return ADDR_W'(int'(r) * MAP_W + int'(c));
    endfunction

    // Pick one quadrant subtile from the neighbor mask
    function automatic result_t quad_pick(logic [7:0] nb, logic [7:0] base,
                                          logic [1:0] q);
        result_t    res;
        quad_rule_t rule;
        logic [2:0] fl;
        rule = QUAD_RULES[q];
        if ((nb & rule.full) == rule.full) begin
            res.tile_id = base;
            fl = rule.bflags;
        end
        else if ((nb & rule.cc1) == rule.cc1) begin
            res.tile_id = base + 8'd3;
            fl = rule.bflags;
        end
        else if ((nb & rule.cc2) == rule.cc2) begin
            res.tile_id = base + 8'd3;
            fl = rule.sflags;
        end
        else if ((nb & rule.hbit) != 8'h00) begin
            res.tile_id = base + 8'd2;
            fl = rule.bflags;
        end
        else if ((nb & rule.vbit) != 8'h00) begin
            res.tile_id = base + 8'd2;
            fl = rule.sflags;
        end
        else begin
            res.tile_id = base + 8'd1;
            fl = rule.bflags;
        end
        res.flip_x   = fl[0];
        res.flip_y   = fl[1];
        res.swap_xy  = fl[2];
        res.quadrant = {1'b0, q} + 3'd1;
        res.last     = (q == 2'd3);
        return res;
    endfunction

endpackage

[rtl/core/qas_map_ram.sv]
// ----------------------------------------------------------------------------
// qas_map_ram
// Tile map storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module qas_map_ram (
    input  logic               clk,
    input  qas_pkg::ram_req_t  req,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [qas_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

[rtl/core/qas_seq.sv]
// ----------------------------------------------------------------------------
// qas_seq
// Sequencer: walks the cell and its eight neighbors through the single map
// read port, builds the match mask, then steps out the result words.
// ----------------------------------------------------------------------------
module qas_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          operation,
    input  logic [qas_pkg::COORD_W-1:0]   col,
    input  logic [qas_pkg::COORD_W-1:0]   row,
    input  logic [7:0]                    tile_value,
    output qas_pkg::ram_req_t             ram_req,
    input  logic [7:0]                    ram_rd_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output qas_pkg::result_t              res
);

    qas_pkg::seq_state_t state_reg, state_next;
    logic [3:0]                  slot_reg, slot_next;
    logic                        pend_reg, pend_next;
    logic                        pend_self_reg, pend_self_next;
    logic [qas_pkg::COORD_W-1:0] col_reg, col_next;
    logic [qas_pkg::COORD_W-1:0] row_reg, row_next;
    logic [7:0]                  self_reg, self_next;
    logic [7:0]                  nb_reg, nb_next;
    logic [1:0]                  q_reg, q_next;

    logic                        accept;
    logic                        in_map;
    logic                        single;
    logic [qas_pkg::COORD_W-1:0] lx, rx, ty, by;
    logic [3:0]                  goal_idx;

    assign accept = req_valid && !req_stall;
    assign in_map = (int'(col) < qas_pkg::MAP_W) && (int'(row) < qas_pkg::MAP_H);
    assign single = (self_reg >= qas_pkg::TILE_RAW) || (self_reg == qas_pkg::TILE_GOAL);

    // Toroidal wrap of the neighbor coordinates
    assign lx = (col_reg == '0) ? qas_pkg::COORD_W'(qas_pkg::MAP_W - 1)
                                : col_reg - 1'b1;
    assign rx = (int'(col_reg) + 1 >= qas_pkg::MAP_W) ? '0 : col_reg + 1'b1;
    assign ty = (row_reg == '0) ? qas_pkg::COORD_W'(qas_pkg::MAP_H - 1)
                                : row_reg - 1'b1;
    assign by = (int'(row_reg) + 1 >= qas_pkg::MAP_H) ? '0 : row_reg + 1'b1;

    // mask bits: 7 NW, 6 N, 4 W, 3 E, 1 S
    assign goal_idx = {nb_reg[6], nb_reg[4], nb_reg[3], nb_reg[1]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qas_pkg::ST_IDLE:
            begin
                if (accept && in_map && operation == qas_pkg::OP_RENDER)
                begin
                    state_next = qas_pkg::ST_FETCH;
                end
            end
            qas_pkg::ST_FETCH:
            begin
                if (slot_reg == qas_pkg::SLOT_LAST)
                begin
                    state_next = qas_pkg::ST_DRAIN;
                end
            end
            qas_pkg::ST_DRAIN:
            begin
                state_next = qas_pkg::ST_EMIT;
            end
            qas_pkg::ST_EMIT:
            begin
                if (res_ready && (single || q_reg == 2'd3))
                begin
                    state_next = qas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qas_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_stall     = (state_reg != qas_pkg::ST_IDLE);
        ram_req.we    = (state_reg == qas_pkg::ST_IDLE) && accept && in_map
                        && (operation == qas_pkg::OP_WRITE);
        ram_req.waddr = qas_pkg::cell_addr(col, row);
        ram_req.wdata = tile_value;
        unique case (slot_reg)
            4'd0:    ram_req.raddr = qas_pkg::cell_addr(col_reg, row_reg);
            4'd1:    ram_req.raddr = qas_pkg::cell_addr(lx, ty);
            4'd2:    ram_req.raddr = qas_pkg::cell_addr(col_reg, ty);
            4'd3:    ram_req.raddr = qas_pkg::cell_addr(rx, ty);
            4'd4:    ram_req.raddr = qas_pkg::cell_addr(lx, row_reg);
            4'd5:    ram_req.raddr = qas_pkg::cell_addr(rx, row_reg);
            4'd6:    ram_req.raddr = qas_pkg::cell_addr(lx, by);
            4'd7:    ram_req.raddr = qas_pkg::cell_addr(col_reg, by);
            default: ram_req.raddr = qas_pkg::cell_addr(rx, by);
        endcase

        res_valid = (state_reg == qas_pkg::ST_EMIT);
        if (self_reg >= qas_pkg::TILE_RAW)
        begin
            res = '{tile_id: self_reg, flip_x: 1'b0, flip_y: 1'b0, swap_xy: 1'b0,
                    quadrant: qas_pkg::QUAD_WHOLE, last: 1'b1};
        end
        else if (self_reg == qas_pkg::TILE_GOAL)
        begin
            res = '{tile_id: qas_pkg::GOAL_TILES[goal_idx], flip_x: 1'b0,
                    flip_y: 1'b0, swap_xy: 1'b0,
                    quadrant: qas_pkg::QUAD_WHOLE, last: 1'b1};
        end
        else
        begin
            res = qas_pkg::quad_pick(nb_reg,
                (self_reg == qas_pkg::TILE_VACANT) ? qas_pkg::BASE_VACANT
                                                   : qas_pkg::BASE_SOLID,
                q_reg);
        end
    end

    // Datapath next values
    always_comb
    begin
        slot_next      = slot_reg;
        pend_next      = (state_reg == qas_pkg::ST_FETCH);
        pend_self_next = (state_reg == qas_pkg::ST_FETCH) && (slot_reg == '0);
        col_next       = col_reg;
        row_next       = row_reg;
        self_next      = self_reg;
        nb_next        = nb_reg;
        q_next         = q_reg;

        if (state_reg == qas_pkg::ST_IDLE && accept)
        begin
            col_next  = col;
            row_next  = row;
            slot_next = '0;
            q_next    = '0;
        end
        if (state_reg == qas_pkg::ST_FETCH)
        begin
            slot_next = slot_reg + 4'd1;
        end
        // Read data lands in the cycle after its address; neighbors shift in NW first
        if (pend_reg)
        begin
            if (pend_self_reg)
            begin
                self_next = ram_rd_data;
            end
            else
            begin
                nb_next = {nb_reg[6:0], qas_pkg::tile_match(self_reg, ram_rd_data)};
            end
        end
        if (state_reg == qas_pkg::ST_EMIT && res_ready)
        begin
            q_next = q_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qas_pkg::ST_IDLE;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_self_reg <= 1'b0;
            q_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            pend_self_reg <= pend_self_next;
            q_reg         <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        row_reg  <= row_next;
        self_reg <= self_next;
        nb_reg   <= nb_next;
    end

endmodule

[rtl/core/quadrant_autotile_selector_unit.sv]
// ----------------------------------------------------------------------------
// quadrant_autotile_selector_unit
// A render reads the cell and its eight neighbors through one map read port,
// passes through the drain state, then loads the output register.
// A render holds the input until its whole-cell result or its four quadrant
// words are taken, and output stalls lengthen it; a write does not stall the input.
// Reset: clears the sequencer control state and output valid; map contents are undefined.
// ----------------------------------------------------------------------------
module quadrant_autotile_selector_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          operation,
    input  logic [qas_pkg::COORD_W-1:0]   col,
    input  logic [qas_pkg::COORD_W-1:0]   row,
    input  logic [7:0]                    tile_value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [7:0]                    tile_id,
    output logic                          flip_x,
    output logic                          flip_y,
    output logic                          swap_xy,
    output logic [2:0]                    quadrant,
    output logic                          last
);

    qas_pkg::ram_req_t ram_req;
    logic [7:0]        ram_rd_data;
    logic              res_valid;
    logic              res_ready;
    qas_pkg::result_t  res;

    logic              out_valid_reg, out_valid_next;
    qas_pkg::result_t  out_reg, out_next;

    qas_map_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    qas_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .col         (col),
        .row         (row),
        .tile_value  (tile_value),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Load a new word when the output register is empty or being taken
    assign res_ready = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign tile_id   = out_reg.tile_id;
    assign flip_x    = out_reg.flip_x;
    assign flip_y    = out_reg.flip_y;
    assign swap_xy   = out_reg.swap_xy;
    assign quadrant  = out_reg.quadrant;
    assign last      = out_reg.last;

endmodule
